// ----- rtl/pdmwl_pkg.sv -----
// Shared types and constants for the PDM window level detector.
package pdmwl_pkg;

  localparam int WORD_BITS      = 16;
  localparam int FRAME_WORDS_W  = 9;
  localparam int LEVEL_W        = 19;
  localparam int CFG_DATA_W     = 19;
  localparam int CFG_INDEX_W    = 1;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [FRAME_WORDS_W-1:0] FRAME_WORDS_RESET = FRAME_WORDS_W'(150);
  localparam logic [LEVEL_W-1:0]       THRESHOLD_RESET   = LEVEL_W'(17000);
  localparam logic [LEVEL_W-1:0]       LEVEL_MAX         = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WORDS    = 1'b0,
    REG_LOUD_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

endpackage

// ----- rtl/pdm_window_level_detector.sv -----
// Top level of the PDM window level detector: registers, queue, front end and bit engine.
// Each accepted 16-bit PDM word is processed one bit per clock in the bit engine, except
// while it is held at a frame's final bit; a two-word queue lets the input keep taking
// words while the engine works or while a finished result waits. The frame result appears
// on frame_level and is_loud in the cycle after the last bit of the frame's last word, and
// is held until taken; while held, the engine stops only at the final bit of the next
// frame. frame_words and loud_threshold may be written only while no request is in flight.
module pdm_window_level_detector import pdmwl_pkg::*; #(
  parameter int MAX_FRAME_WORDS = 256,
  parameter int WINDOW_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [WORD_BITS-1:0]   pdm_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [LEVEL_W-1:0]     frame_level,
  output logic                   is_loud
);

  logic [FRAME_WORDS_W-1:0] frame_words;
  logic [LEVEL_W-1:0]       loud_threshold;
  logic                     push;
  queue_entry_t             push_entry;
  logic                     queue_full;
  logic                     pop;
  queue_head_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words    <= FRAME_WORDS_RESET;
      loud_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WORDS:    frame_words    <= cfg_data[FRAME_WORDS_W-1:0];
        REG_LOUD_THRESHOLD: loud_threshold <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = queue_full;

  pdmwl_front #(
    .MAX_FRAME_WORDS(MAX_FRAME_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .pdm_word   (pdm_word),
    .frame_words(frame_words),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pdmwl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (queue_full),
    .head      (head)
  );

  pdmwl_back #(
    .MAX_FRAME_WORDS(MAX_FRAME_WORDS),
    .WINDOW_BITS    (WINDOW_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .loud_threshold(loud_threshold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_level   (frame_level),
    .is_loud       (is_loud)
  );

endmodule

// ----- rtl/pdmwl_front.sv -----
// Front end: accepts PDM words and marks the last word of each frame.
module pdmwl_front import pdmwl_pkg::*; #(
  parameter int MAX_FRAME_WORDS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [WORD_BITS-1:0]     pdm_word,
  input  logic [FRAME_WORDS_W-1:0] frame_words,
  input  logic                     queue_full,
  output logic                     push,
  output queue_entry_t             push_entry
);

  localparam int CNT_W  = $clog2(MAX_FRAME_WORDS);
  localparam int MAXB_W = $clog2(MAX_FRAME_WORDS + 1);
  localparam int EFF_W  = ((MAXB_W > FRAME_WORDS_W) ? MAXB_W : FRAME_WORDS_W) + 1;

  logic [CNT_W-1:0] word_cnt;
  logic [CNT_W-1:0] word_cnt_next;
  logic [EFF_W-1:0] fw_ext;
  logic [EFF_W-1:0] eff_words;
  logic [EFF_W-1:0] cnt_plus_one;
  logic             is_last;

  always_comb begin
    fw_ext = EFF_W'(frame_words);
    if (fw_ext < EFF_W'(2)) begin
      eff_words = EFF_W'(2);
    end else if (fw_ext > EFF_W'(MAX_FRAME_WORDS)) begin
      eff_words = EFF_W'(MAX_FRAME_WORDS);
    end else begin
      eff_words = fw_ext;
    end
    cnt_plus_one = EFF_W'(word_cnt) + EFF_W'(1);
    is_last      = (cnt_plus_one >= eff_words);
    word_cnt_next = is_last ? '0 : CNT_W'(cnt_plus_one);
  end

  assign push            = in_valid && !queue_full;
  assign push_entry.word = pdm_word;
  assign push_entry.last = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_cnt <= '0;
    end else if (push) begin
      word_cnt <= word_cnt_next;
    end
  end

endmodule

// ----- rtl/pdmwl_queue.sv -----
// Two-entry request queue between the front end and the bit engine.
module pdmwl_queue import pdmwl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output logic         full,
  output queue_head_t  head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full        = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid  = (count != '0);
  assign head.entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/pdmwl_back.sv -----
// Bit engine: sliding window deviation, frame accumulation and result register.
module pdmwl_back import pdmwl_pkg::*; #(
  parameter int MAX_FRAME_WORDS = 256,
  parameter int WINDOW_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  queue_head_t        head,
  output logic               pop,
  input  logic [LEVEL_W-1:0] loud_threshold,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] frame_level,
  output logic               is_loud
);

  localparam int W      = WINDOW_BITS;
  localparam int OW     = $clog2(W + 1);
  localparam int DW     = $clog2(W / 2 + 1);
  localparam int SW     = $clog2(W * (W / 2) + 1);
  localparam int ACC_RAW = $clog2(WORD_BITS * MAX_FRAME_WORDS * W * (W / 2) + 1);
  localparam int AW     = (ACC_RAW > LEVEL_W) ? ACC_RAW : LEVEL_W + 1;
  localparam int PW     = $clog2(2 * W - 1);
  localparam int BW     = $clog2(WORD_BITS);
  localparam logic [OW-1:0] HALF     = OW'(W / 2);
  localparam logic [PW-1:0] DEV_POS  = PW'(W - 1);
  localparam logic [PW-1:0] ACC_POS  = PW'(2 * W - 2);
  localparam logic [BW-1:0] BIT_LAST = BW'(WORD_BITS - 1);

  logic                 busy;
  logic                 last;
  logic [WORD_BITS-1:0] word;
  logic [BW-1:0]        bit_cnt;

  logic [W-1:0]  bit_history;
  logic [OW-1:0] ones_in_window;
  logic [DW-1:0] deviation_history [W];
  logic [SW-1:0] deviation_window_sum;
  logic [AW-1:0] level_accumulator;
  logic [PW-1:0] bit_position;

  logic               bit_in;
  logic               leaving;
  logic               word_end;
  logic               final_bit;
  logic               step;
  logic               in_dev;
  logic               in_acc;
  logic [OW-1:0]      ones_next;
  logic [DW-1:0]      dev;
  logic [SW-1:0]      sum_next;
  logic [AW-1:0]      acc_next;
  logic [LEVEL_W-1:0] level_sat;

  always_comb begin
    bit_in    = word[WORD_BITS-1];
    leaving   = bit_history[W-1];
    word_end  = (bit_cnt == BIT_LAST);
    final_bit = last && word_end;
    step      = busy && !(final_bit && out_valid && out_stall);
    pop       = head.valid && (!busy || (step && word_end));

    in_dev    = (bit_position >= DEV_POS);
    in_acc    = (bit_position >= ACC_POS);
    ones_next = ones_in_window + OW'(bit_in) - OW'(leaving);
    if (ones_next >= HALF) begin
      dev = DW'(ones_next - HALF);
    end else begin
      dev = DW'(HALF - ones_next);
    end
    sum_next = in_dev ? deviation_window_sum + SW'(dev) - SW'(deviation_history[W-1])
                      : deviation_window_sum;
    acc_next = in_acc ? level_accumulator + AW'(sum_next) : level_accumulator;
    if (acc_next[AW-1:LEVEL_W] != '0) begin
      level_sat = LEVEL_MAX;
    end else begin
      level_sat = acc_next[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      last    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      if (step) begin
        bit_cnt <= bit_cnt + BW'(1);
      end
      if (pop) begin
        busy    <= 1'b1;
        last    <= head.entry.last;
        bit_cnt <= '0;
      end else if (step && word_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word <= head.entry.word;
    end else if (step) begin
      word <= {word[WORD_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && final_bit)) begin
      bit_history          <= '0;
      ones_in_window       <= '0;
      deviation_window_sum <= '0;
      level_accumulator    <= '0;
      bit_position         <= '0;
      for (int k = 0; k < W; k++) begin
        deviation_history[k] <= '0;
      end
    end else if (step) begin
      bit_history       <= {bit_history[W-2:0], bit_in};
      ones_in_window    <= ones_next;
      level_accumulator <= acc_next;
      if (bit_position != ACC_POS) begin
        bit_position <= bit_position + PW'(1);
      end
      if (in_dev) begin
        deviation_window_sum <= sum_next;
        for (int k = W - 1; k > 0; k--) begin
          deviation_history[k] <= deviation_history[k-1];
        end
        deviation_history[0] <= dev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && final_bit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && final_bit) begin
      frame_level <= level_sat;
      is_loud     <= (level_sat > loud_threshold);
    end
  end

endmodule

// ----- rtl/pdmwl_checker.sv -----
// Port-level checker for the PDM window level detector, bound to the top level.
module pdmwl_checker import pdmwl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] frame_level,
  input logic               is_loud
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_level) && $stable(is_loud))
    else $error("result changed while stalled");

  a_loud_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_loud |-> frame_level != '0)
    else $error("loud flag with zero level");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind pdm_window_level_detector pdmwl_checker u_pdmwl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_level(frame_level),
  .is_loud    (is_loud)
);
